>>> hdl/pmg_pkg.sv
// Shared types, register codes and constant functions for the polynomial mutation block.
`timescale 1ns / 1ps
`default_nettype none

package pmg_pkg;

  // Configuration register indexes
  localparam logic [0:0] CFG_PROB = 1'b0;
  localparam logic [0:0] CFG_ETA  = 1'b1;

  localparam logic [16:0] PROB_RESET = 17'd0;
  localparam logic [15:0] ETA_RESET  = 16'd3840;   // fifteen in Q8.8
  localparam logic [16:0] ONE_Q16    = 17'd65536;
  localparam logic [15:0] HALF_Q16   = 16'd32768;

  // Per-word data that rides along with the arithmetic pipeline
  typedef struct packed {
    logic signed [31:0] y;
    logic signed [31:0] yl;
    logic signed [31:0] yu;
    logic [15:0]        t;     // distance of the shape random from its branch end
    logic               lo;    // lower branch
    logic               mut;   // mutation applies
    logic               last;
    logic               dz;    // delta forced to zero
    logic               df;    // delta forced to one
    logic               xz;    // pow base is zero
    logic               vz;    // root base is zero
  } pmg_side_t;

  // Floor square root, evaluated at elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] rem;
    r   = 64'd0;
    b   = 64'h4000_0000_0000_0000;
    rem = v;
    for (int i = 0; i < 32; i++) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r   = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(2^-i) in Q2.30, each the floor root of the one before
  function automatic logic [30:0] exp_const(input int i);
    logic [63:0] c;
    c = 64'h8000_0000;
    for (int j = 1; j <= i; j++) begin
      c = isqrt64(c << 30);
    end
    return c[30:0];
  endfunction

endpackage

`default_nettype wire

>>> hdl/pmg_if.sv
// Valid/ready channel interfaces for gene words and result words.
`timescale 1ns / 1ps
`default_nettype none

interface pmg_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] gene_value;
  logic signed [31:0] lower_limit;
  logic signed [31:0] upper_limit;
  logic [15:0]        gate_random;
  logic [15:0]        shape_random;
  logic               gene_last;

  modport source (output valid, gene_value, lower_limit, upper_limit, gate_random,
                  shape_random, gene_last, input ready);
  modport sink   (input valid, gene_value, lower_limit, upper_limit, gate_random,
                  shape_random, gene_last, output ready);
endinterface

interface pmg_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_value;
  logic               was_mutated;
  logic               result_last;

  modport source (output valid, new_value, was_mutated, result_last, input ready);
  modport sink   (input valid, new_value, was_mutated, result_last, output ready);
endinterface

`default_nettype wire

>>> hdl/polynomial_mutation_gene.sv
// Top level of the bounded polynomial mutation engine for one gene per word.
//
// One gene word enters per clock; the whole pipeline advances together and
// only stops while a finished result is held at the output. Each word passes
// a chain of bit-serial stages: a 17-stage divider for the normalized
// distance, a log2/exp2 pair for the power, a second log2, a 21-stage
// divider by eta+1 and an exp2 for the root. Write registers only while no
// word is in flight; the block does not enforce it. Index 0 is the mutation
// probability (Q0.16, 65536 means always), index 1 is eta (Q8.8).
`timescale 1ns / 1ps
`default_nettype none

module polynomial_mutation_gene (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [16:0] cfg_data,
  pmg_in_if.sink           gene_in,
  pmg_out_if.source        result
);

  localparam int SW = $bits(pmg_pkg::pmg_side_t);

  logic [16:0] prob;
  logic [15:0] eta;
  logic [16:0] e;
  logic        en;
  logic        accept;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prob <= pmg_pkg::PROB_RESET;
      eta  <= pmg_pkg::ETA_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        pmg_pkg::CFG_PROB: prob <= cfg_data;
        pmg_pkg::CFG_ETA:  eta  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign e = {1'b0, eta} + 17'd256;

  // Whole pipeline moves unless the output word is held
  logic out_valid;
  assign en            = !out_valid || result.ready;
  assign gene_in.ready = en;
  assign accept        = gene_in.valid && en;

  // Front end: branch, limits and distance numerator
  pmg_pkg::pmg_side_t side_a;
  logic signed [32:0] span_in;
  logic signed [32:0] diff;
  logic               lo;

  always_comb begin
    lo      = gene_in.shape_random <= pmg_pkg::HALF_Q16;
    span_in = {gene_in.upper_limit[31], gene_in.upper_limit}
            - {gene_in.lower_limit[31], gene_in.lower_limit};
    diff    = lo ? ({gene_in.gene_value[31], gene_in.gene_value}
                    - {gene_in.lower_limit[31], gene_in.lower_limit})
                 : ({gene_in.upper_limit[31], gene_in.upper_limit}
                    - {gene_in.gene_value[31], gene_in.gene_value});
    side_a.y    = gene_in.gene_value;
    side_a.yl   = gene_in.lower_limit;
    side_a.yu   = gene_in.upper_limit;
    side_a.t    = lo ? gene_in.shape_random
                     : 16'(pmg_pkg::ONE_Q16 - {1'b0, gene_in.shape_random});
    side_a.lo   = lo;
    side_a.mut  = (prob != 17'd0) && ({1'b0, gene_in.gate_random} <= prob)
                  && (gene_in.lower_limit < gene_in.upper_limit);
    side_a.last = gene_in.gene_last;
    side_a.dz   = lo ? (gene_in.gene_value <= gene_in.lower_limit)
                     : (gene_in.gene_value >= gene_in.upper_limit);
    side_a.df   = lo ? (gene_in.gene_value >= gene_in.upper_limit)
                     : (gene_in.gene_value <= gene_in.lower_limit);
    side_a.xz   = 1'b0;
    side_a.vz   = 1'b0;
  end

  // Normalized distance delta = diff / span
  logic          d1_valid;
  logic [16:0]   d1_q;
  logic [SW-1:0] d1_side;

  pmg_div #(.NW(49), .DW(33), .QW(17), .SW(SW)) u_div_delta (
    .clk, .rst, .en,
    .in_valid (accept),
    .num      ({diff, 16'd0}),
    .den      (span_in),
    .in_side  (side_a),
    .out_valid(d1_valid),
    .quot     (d1_q),
    .out_side (d1_side)
  );

  // Pow base 1 - delta
  pmg_pkg::pmg_side_t side_b;
  logic [16:0]        delta;
  logic [16:0]        xbase;

  always_comb begin
    side_b = d1_side;
    if (side_b.dz) begin
      delta = 17'd0;
    end else if (side_b.df) begin
      delta = pmg_pkg::ONE_Q16;
    end else begin
      delta = d1_q;
    end
    xbase     = pmg_pkg::ONE_Q16 - delta;
    side_b.xz = xbase == 17'd0;
  end

  logic          l1_valid;
  logic [20:0]   l1_val;
  logic [SW-1:0] l1_side;

  pmg_log #(.SW(SW)) u_log_pow (
    .clk, .rst, .en,
    .in_valid (d1_valid),
    .x        (xbase),
    .in_side  (side_b),
    .out_valid(l1_valid),
    .nlog     (l1_val),
    .out_side (l1_side)
  );

  // Exponent of the power: -log2(x) * (eta + 1)
  logic [37:0]   le;
  logic          c_valid;
  logic [29:0]   c_u;
  logic [SW-1:0] c_side;

  assign le = {17'd0, l1_val} * {21'd0, e};

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= l1_valid;
    end
    if (en) begin
      c_u    <= le[37:8];
      c_side <= l1_side;
    end
  end

  logic          p_valid;
  logic [16:0]   p_pw;
  logic [SW-1:0] p_side;

  pmg_exp #(.UW(30), .SW(SW)) u_exp_pow (
    .clk, .rst, .en,
    .in_valid (c_valid),
    .u        (c_u),
    .in_side  (c_side),
    .out_valid(p_valid),
    .res      (p_pw),
    .out_side (p_side)
  );

  // Root base: 2t + (1 - 2t) * pw
  pmg_pkg::pmg_side_t side_p;
  pmg_pkg::pmg_side_t side_d;
  logic [16:0]        pw;
  logic [16:0]        t2;
  logic [33:0]        mp;
  logic [17:0]        val_w;
  logic               d_valid;
  logic [16:0]        d_val;
  logic [SW-1:0]      d_side;

  always_comb begin
    side_p    = p_side;
    pw        = side_p.xz ? 17'd0 : p_pw;
    t2        = {side_p.t, 1'b0};
    mp        = {17'd0, pmg_pkg::ONE_Q16 - t2} * {17'd0, pw};
    val_w     = {1'b0, t2} + mp[33:16];
    side_d    = side_p;
    side_d.vz = val_w[16:0] == 17'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= p_valid;
    end
    if (en) begin
      d_val  <= val_w[16:0];
      d_side <= side_d;
    end
  end

  logic          l2_valid;
  logic [20:0]   l2_val;
  logic [SW-1:0] l2_side;

  pmg_log #(.SW(SW)) u_log_root (
    .clk, .rst, .en,
    .in_valid (d_valid),
    .x        (d_val),
    .in_side  (d_side),
    .out_valid(l2_valid),
    .nlog     (l2_val),
    .out_side (l2_side)
  );

  // Root exponent: -log2(val) / (eta + 1)
  logic          q2_valid;
  logic [20:0]   q2_u;
  logic [SW-1:0] q2_side;

  pmg_div #(.NW(29), .DW(17), .QW(21), .SW(SW)) u_div_root (
    .clk, .rst, .en,
    .in_valid (l2_valid),
    .num      ({l2_val, 8'd0}),
    .den      (e),
    .in_side  (l2_side),
    .out_valid(q2_valid),
    .quot     (q2_u),
    .out_side (q2_side)
  );

  logic          r_valid;
  logic [16:0]   r_root;
  logic [SW-1:0] r_side;

  pmg_exp #(.UW(21), .SW(SW)) u_exp_root (
    .clk, .rst, .en,
    .in_valid (q2_valid),
    .u        (q2_u),
    .in_side  (q2_side),
    .out_valid(r_valid),
    .res      (r_root),
    .out_side (r_side)
  );

  // Step before scaling: deltaq * span
  pmg_pkg::pmg_side_t side_r;
  logic [16:0]        root;
  logic signed [17:0] dq;
  logic signed [33:0] span;
  logic signed [51:0] dq_x;
  logic signed [51:0] span_x;
  logic               f_valid;
  logic signed [51:0] f_prod;
  logic [SW-1:0]      f_side;

  always_comb begin
    side_r = r_side;
    root   = side_r.vz ? 17'd0 : r_root;
    dq     = side_r.lo ? ({1'b0, root} - 18'sd65536) : (18'sd65536 - {1'b0, root});
    span   = {{2{side_r.yu[31]}}, side_r.yu} - {{2{side_r.yl[31]}}, side_r.yl};
    dq_x   = {{34{dq[17]}}, dq};
    span_x = {{18{span[33]}}, span};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= r_valid;
    end
    if (en) begin
      f_prod <= dq_x * span_x;
      f_side <= side_r;
    end
  end

  // Apply step, clamp to limits, register the result word
  pmg_pkg::pmg_side_t side_f;
  logic signed [36:0] res;
  logic signed [36:0] yl_x;
  logic signed [36:0] yu_x;
  logic signed [31:0] mutated;
  logic signed [31:0] new_value;
  logic               was_mutated;
  logic               result_last;

  always_comb begin
    side_f = f_side;
    yl_x   = {{5{side_f.yl[31]}}, side_f.yl};
    yu_x   = {{5{side_f.yu[31]}}, side_f.yu};
    res    = {{5{side_f.y[31]}}, side_f.y} + {f_prod[51], f_prod[51:16]};
    if (res < yl_x) begin
      mutated = side_f.yl;
    end else if (res > yu_x) begin
      mutated = side_f.yu;
    end else begin
      mutated = res[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= f_valid;
    end
    if (en) begin
      new_value   <= side_f.mut ? mutated : side_f.y;
      was_mutated <= side_f.mut;
      result_last <= side_f.last;
    end
  end

  assign result.valid       = out_valid;
  assign result.new_value   = new_value;
  assign result.was_mutated = was_mutated;
  assign result.result_last = result_last;

endmodule

`default_nettype wire

>>> hdl/pmg_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module pmg_div #(
  parameter int NW = 49,
  parameter int DW = 33,
  parameter int QW = 17,
  parameter int SW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  output logic [QW-1:0]      quot,
  output logic [SW-1:0]      out_side
);

  logic          v_r    [0:QW];
  logic [DW-1:0] rem_r  [0:QW];
  logic [QW-1:0] low_r  [0:QW];
  logic [QW-1:0] q_r    [0:QW];
  logic [DW-1:0] d_r    [0:QW];
  logic [SW-1:0] side_r [0:QW];

  // Load: high numerator bits are the starting remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
    if (en) begin
      rem_r[0]  <= DW'(num >> QW);
      low_r[0]  <= num[QW-1:0];
      q_r[0]    <= '0;
      d_r[0]    <= den;
      side_r[0] <= in_side;
    end
  end

  // One trial subtraction per stage
  for (genvar s = 1; s <= QW; s++) begin : g_step
    logic [DW:0] trial;
    logic        ge;

    assign trial = {rem_r[s-1], low_r[s-1][QW-1]};
    assign ge    = trial >= {1'b0, d_r[s-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_r[s-1];
      end
      if (en) begin
        rem_r[s]  <= ge ? DW'(trial - {1'b0, d_r[s-1]}) : trial[DW-1:0];
        low_r[s]  <= {low_r[s-1][QW-2:0], 1'b0};
        q_r[s]    <= {q_r[s-1][QW-2:0], ge};
        d_r[s]    <= d_r[s-1];
        side_r[s] <= side_r[s-1];
      end
    end
  end

  assign out_valid = v_r[QW];
  assign quot      = q_r[QW];
  assign out_side  = side_r[QW];

endmodule

`default_nettype wire

>>> hdl/pmg_log.sv
// Pipelined -log2 of a Q0.16 value by sixteen squaring stages, result in Q.16.
`timescale 1ns / 1ps
`default_nettype none

module pmg_log #(
  parameter int SW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [16:0]   x,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  output logic [20:0]        nlog,
  output logic [SW-1:0]      out_side
);

  logic          v_r    [0:16];
  logic [30:0]   m_r    [0:16];
  logic [4:0]    k_r    [0:16];
  logic [15:0]   frac_r [0:16];
  logic [SW-1:0] side_r [0:16];

  logic [4:0]    k;
  logic [30:0]   m0;
  logic          v_o;
  logic [20:0]   nlog_o;
  logic [SW-1:0] side_o;

  // Leading one position, then normalize to [1,2) in Q2.30
  always_comb begin
    k = 5'd0;
    for (int i = 0; i < 17; i++) begin
      if (x[i]) k = 5'(i);
    end
  end
  assign m0 = 31'({14'd0, x} << (5'd30 - k));

  always_ff @(posedge clk) begin
    if (rst) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
    if (en) begin
      m_r[0]    <= m0;
      k_r[0]    <= k;
      frac_r[0] <= '0;
      side_r[0] <= in_side;
    end
  end

  // Square; a carry into bit 31 gives the next fraction bit
  for (genvar s = 1; s <= 16; s++) begin : g_sq
    logic [61:0] sq;
    logic [31:0] sh;

    assign sq = {31'd0, m_r[s-1]} * {31'd0, m_r[s-1]};
    assign sh = sq[61:30];

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_r[s-1];
      end
      if (en) begin
        m_r[s]    <= sh[31] ? sh[31:1] : sh[30:0];
        frac_r[s] <= {frac_r[s-1][14:0], sh[31]};
        k_r[s]    <= k_r[s-1];
        side_r[s] <= side_r[s-1];
      end
    end
  end

  // -log2 = (16 - k) - fraction
  always_ff @(posedge clk) begin
    if (rst) begin
      v_o <= 1'b0;
    end else if (en) begin
      v_o <= v_r[16];
    end
    if (en) begin
      nlog_o <= {5'd16 - k_r[16], 16'd0} - {5'd0, frac_r[16]};
      side_o <= side_r[16];
    end
  end

  assign out_valid = v_o;
  assign nlog      = nlog_o;
  assign out_side  = side_o;

endmodule

`default_nettype wire

>>> hdl/pmg_exp.sv
// Pipelined 2^-u for a Q.16 exponent, sixteen constant-multiply stages, Q0.16 out.
`timescale 1ns / 1ps
`default_nettype none

module pmg_exp #(
  parameter int UW = 30,
  parameter int SW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [UW-1:0] u,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  output logic [16:0]        res,
  output logic [SW-1:0]      out_side
);

  localparam int NE = UW - 15;

  logic          v_r    [0:16];
  logic [30:0]   acc_r  [0:16];
  logic [15:0]   f_r    [0:16];
  logic [5:0]    sh_r   [0:16];
  logic          big_r  [0:16];
  logic [SW-1:0] side_r [0:16];

  logic [NE-1:0] n;
  logic          big;
  logic          v_o;
  logic [16:0]   res_o;
  logic [SW-1:0] side_o;

  // Integer part rounded up; fraction is what remains to reach it
  assign n   = NE'(u >> 16) + NE'(u[15:0] != 16'd0);
  assign big = n > NE'(20);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
    if (en) begin
      acc_r[0]  <= 31'h4000_0000;
      f_r[0]    <= 16'(16'd0 - u[15:0]);
      sh_r[0]   <= 6'd14 + {1'b0, n[4:0]};
      big_r[0]  <= big;
      side_r[0] <= in_side;
    end
  end

  // Multiply in 2^(2^-s) where fraction bit is set
  for (genvar s = 1; s <= 16; s++) begin : g_mul
    localparam logic [30:0] C = pmg_pkg::exp_const(s);
    logic [61:0] prod;

    assign prod = {31'd0, acc_r[s-1]} * {31'd0, C};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_r[s-1];
      end
      if (en) begin
        acc_r[s]  <= f_r[s-1][16-s] ? prod[60:30] : acc_r[s-1];
        f_r[s]    <= f_r[s-1];
        sh_r[s]   <= sh_r[s-1];
        big_r[s]  <= big_r[s-1];
        side_r[s] <= side_r[s-1];
      end
    end
  end

  // Scale back to Q0.16
  always_ff @(posedge clk) begin
    if (rst) begin
      v_o <= 1'b0;
    end else if (en) begin
      v_o <= v_r[16];
    end
    if (en) begin
      res_o  <= big_r[16] ? 17'd0 : 17'(acc_r[16] >> sh_r[16]);
      side_o <= side_r[16];
    end
  end

  assign out_valid = v_o;
  assign res       = res_o;
  assign out_side  = side_o;

endmodule

`default_nettype wire

>>> hdl/pmg_checker.sv
// Port-level checks for the polynomial mutation block and their bind.
`timescale 1ns / 1ps
`default_nettype none

module pmg_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] new_value,
  input wire logic        was_mutated,
  input wire logic        result_last
);

  // Reset empties the output stage
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid right after reset");

  // Input is only refused while a result word is held
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a held result word");

  // A held result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(new_value)
      && $stable(was_mutated) && $stable(result_last))
    else $error("held result word changed");

endmodule

bind polynomial_mutation_gene pmg_checker u_pmg_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (gene_in.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .new_value  (result.new_value),
  .was_mutated(result.was_mutated),
  .result_last(result.result_last)
);

`default_nettype wire

>>> verif/testbench.sv
// Self-checking bench for the polynomial mutation engine: directed table, then random words.
`timescale 1ns / 1ps

module testbench;

  localparam int LIMIT = 600000;

  // One row of the directed table; typed expectations where chk is set
  typedef struct {
    logic [16:0] prob;
    logic [15:0] eta;
    logic [31:0] y, yl, yu;
    logic [15:0] gate, shape;
    logic        last;
    logic        chk;
    logic [31:0] ev;
    logic        em;
  } row_t;

  typedef struct {
    logic [31:0] val;
    logic        mut;
    logic        last;
  } gene_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [0:0]  cfg_index = pmg_pkg::CFG_PROB;
  logic [16:0] cfg_data = '0;

  pmg_in_if  gene_in();
  pmg_out_if result();

  polynomial_mutation_gene dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .gene_in(gene_in), .result(result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor copy of the configuration
  logic [16:0] cur_prob = pmg_pkg::PROB_RESET;
  logic [15:0] cur_eta = pmg_pkg::ETA_RESET;

  gene_res_t expected_q[$];
  int errors = 0;
  int in_idle = 0;
  int out_stall = 0;
  int cycles = 0;
  logic [63:0] root_tab[1:16];
  row_t dir_tab[22];

  // Floor square root, digit by digit
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] acc, b, rem;
    acc = 0;
    rem = v;
    b = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= acc + b) begin
        rem = rem - (acc + b);
        acc = (acc >> 1) + b;
      end else begin
        acc = acc >> 1;
      end
      b = b >> 2;
    end
    return acc;
  endfunction

  // -log2(x) in Q.16, x in Q0.16 nonzero
  function automatic logic [63:0] neg_lg(input logic [63:0] x);
    int k;
    logic [63:0] m, fr;
    k = 0;
    fr = 0;
    while (k < 16 && (x >> (k + 1)) != 0) k++;
    m = x << (30 - k);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      fr = fr << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        fr = fr | 1;
      end
    end
    return 64'(16 - k) * 65536 - fr;
  endfunction

  // 2^-u in Q0.16
  function automatic logic [63:0] exp_neg(input logic [63:0] u);
    logic [63:0] n, f, acc;
    n = (u + 65535) >> 16;
    if (n > 20) return 0;
    f = n * 65536 - u;
    acc = 64'd1 << 30;
    for (int i = 1; i <= 16; i++)
      if (f[16 - i]) acc = (acc * root_tab[i]) >> 30;
    return acc >> (14 + n);
  endfunction

  function automatic gene_res_t mutate_gene(input logic [31:0] yv, lv, uv,
                                            input logic [15:0] gate, shape,
                                            input logic last);
    gene_res_t res;
    longint y, yl, yu, r, d1, d2, e, pw, v, rt, dq, nv;
    logic [63:0] s;
    y = longint'($signed(yv));
    yl = longint'($signed(lv));
    yu = longint'($signed(uv));
    s = 64'(shape);
    res.last = last;
    res.val = yv;
    res.mut = cur_prob != 0 && {1'b0, gate} <= cur_prob && yl < yu;
    if (res.mut) begin
      r = yu - yl;
      e = longint'(cur_eta) + 256;
      if (y <= yl) d1 = 0;
      else if (y >= yu) d1 = 65536;
      else d1 = ((y - yl) << 16) / r;
      if (y >= yu) d2 = 0;
      else if (y <= yl) d2 = 65536;
      else d2 = ((yu - y) << 16) / r;
      if (s <= 32768) begin
        pw = (d1 == 65536) ? 0 : exp_neg((neg_lg(65536 - d1) * e) >> 8);
        v = 2 * s + (((65536 - 2 * s) * pw) >> 16);
      end else begin
        pw = (d2 == 65536) ? 0 : exp_neg((neg_lg(65536 - d2) * e) >> 8);
        v = 2 * (65536 - s) + (((2 * s - 65536) * pw) >> 16);
      end
      rt = (v == 0) ? 0 : exp_neg((neg_lg(v) << 8) / e);
      dq = (s <= 32768) ? rt - 65536 : 65536 - rt;
      nv = y + ((dq * r) >>> 16);
      if (nv < yl) nv = yl;
      if (nv > yu) nv = yu;
      res.val = nv[31:0];
    end
    return res;
  endfunction

  // Hold one register write for a clock; the caller drops the enable
  task automatic write_reg(input logic [0:0] idx, input logic [16:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx == pmg_pkg::CFG_PROB) cur_prob = data;
    else cur_eta = data[15:0];
  endtask

  // Stop sending and wait until every queued word has come back
  task automatic drain();
    gene_in.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic [16:0] p, input logic [15:0] t);
    drain();
    write_reg(pmg_pkg::CFG_PROB, p);
    write_reg(pmg_pkg::CFG_ETA, {1'b0, t});
    cfg_write <= 1'b0;
  endtask

  // Drive one word and queue its expectation when accepted
  task automatic put_word(input logic [31:0] y, yl, yu, input logic [15:0] gate, shape,
                          input logic last, input logic chk, input logic [31:0] ev,
                          input logic em);
    gene_res_t g;
    while ($urandom_range(99) < in_idle) begin
      gene_in.valid <= 1'b0;
      @(posedge clk);
    end
    gene_in.valid <= 1'b1;
    gene_in.gene_value <= y;
    gene_in.lower_limit <= yl;
    gene_in.upper_limit <= yu;
    gene_in.gate_random <= gate;
    gene_in.shape_random <= shape;
    gene_in.gene_last <= last;
    @(posedge clk);
    while (!gene_in.ready) @(posedge clk);
    g = mutate_gene(y, yl, yu, gate, shape, last);
    if (chk) begin
      g.val = ev;
      g.mut = em;
    end
    expected_q.push_back(g);
  endtask

  // Random word: mostly well-formed limits with the gene between them
  task automatic random_word();
    logic [31:0] a, b, y;
    logic [63:0] span;
    a = $urandom;
    b = $urandom;
    y = $urandom;
    case ($urandom_range(9))
      0: ;
      1: begin
        if ($signed(a) > $signed(b)) {a, b} = {b, a};
        y = ($urandom_range(1) != 0) ? 32'h7fffffff : 32'h80000000;
      end
      default: begin
        if ($urandom_range(2) == 0) b = a + $urandom_range(1, 5000);
        if ($signed(a) > $signed(b)) {a, b} = {b, a};
        if (a == b) a = a - 1;
        span = 64'($signed(b)) - 64'($signed(a)) + 1;
        y = a + 32'(({$urandom, $urandom}) % span);
      end
    endcase
    put_word(y, a, b, 16'($urandom), 16'($urandom), 1'($urandom), 1'b0, '0, 1'b0);
  endtask

  // Result side: random backpressure
  always @(posedge clk) begin
    result.ready <= ($urandom_range(99) >= out_stall);
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    gene_res_t x;
    if (!rst && result.valid && result.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word value=%h mut=%b last=%b", $time,
                 result.new_value, result.was_mutated, result.result_last);
        errors++;
      end else begin
        x = expected_q.pop_front();
        if (result.new_value !== x.val) begin
          $display("%0t: new_value expected %h actual %h", $time, x.val, result.new_value);
          errors++;
        end
        if (result.was_mutated !== x.mut) begin
          $display("%0t: was_mutated expected %b actual %b", $time, x.mut,
                   result.was_mutated);
          errors++;
        end
        if (result.result_last !== x.last) begin
          $display("%0t: result_last expected %b actual %b", $time, x.last,
                   result.result_last);
          errors++;
        end
      end
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [16:0] p;
    logic [15:0] t;
    logic [63:0] c;
    gene_in.valid = 1'b0;
    gene_in.gene_value = '0;
    gene_in.lower_limit = '0;
    gene_in.upper_limit = '0;
    gene_in.gate_random = '0;
    gene_in.shape_random = '0;
    gene_in.gene_last = 1'b0;
    result.ready = 1'b0;
    c = 64'd1 << 31;
    for (int i = 1; i <= 16; i++) begin
      c = floor_sqrt(c << 30);
      root_tab[i] = c;
    end

    // prob, eta, gene, lower, upper, gate, shape, last, chk, expected value, mutated
    dir_tab[0]  = '{0, 3840, 32'h0001_0000, 32'h0, 32'h0002_0000, 0, 100, 0, 1,
                    32'h0001_0000, 0};
    dir_tab[1]  = '{0, 3840, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 0, 65535, 1, 1,
                    32'h8000_0000, 0};
    dir_tab[2]  = '{32768, 3840, 32'h0000_8000, 32'h0, 32'h0001_0000, 32769, 0, 0, 1,
                    32'h0000_8000, 0};
    dir_tab[3]  = '{32768, 3840, 32'h0000_8000, 32'h0, 32'h0001_0000, 32768, 0, 1, 0, 0, 0};
    dir_tab[4]  = '{65536, 3840, 32'h0003_0000, 32'h0003_0000, 32'h0003_0000, 0, 500, 0, 1,
                    32'h0003_0000, 0};
    dir_tab[5]  = '{65536, 3840, 32'h0001_0000, 32'h0005_0000, 32'h0002_0000, 65535, 500, 1,
                    1, 32'h0001_0000, 0};
    dir_tab[6]  = '{65536, 3840, 32'h0001_0000, 32'h0, 32'h0004_0000, 65535, 0, 0, 0, 0, 0};
    dir_tab[7]  = '{65536, 3840, 32'h0001_0000, 32'h0, 32'h0004_0000, 0, 32768, 0, 0, 0, 0};
    dir_tab[8]  = '{65536, 3840, 32'h0001_0000, 32'h0, 32'h0004_0000, 0, 32769, 1, 0, 0, 0};
    dir_tab[9]  = '{65536, 3840, 32'h0001_0000, 32'h0, 32'h0004_0000, 0, 65535, 0, 0, 0, 0};
    dir_tab[10] = '{65536, 3840, 32'hffff_0000, 32'h0, 32'h0004_0000, 0, 1000, 0, 0, 0, 0};
    dir_tab[11] = '{65536, 3840, 32'h0009_0000, 32'h0, 32'h0004_0000, 0, 60000, 0, 0, 0, 0};
    dir_tab[12] = '{65536, 3840, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 1, 0, 0,
                    0};
    dir_tab[13] = '{65536, 3840, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0, 65535, 0, 0,
                    0, 0};
    dir_tab[14] = '{65536, 3840, 32'h0, 32'h8000_0000, 32'h7fff_ffff, 0, 12345, 1, 0, 0, 0};
    dir_tab[15] = '{65536, 0, 32'h0001_0000, 32'h0, 32'h0004_0000, 0, 1000, 0, 0, 0, 0};
    dir_tab[16] = '{65536, 0, 32'h0003_0000, 32'h0, 32'h0004_0000, 0, 50000, 0, 0, 0, 0};
    dir_tab[17] = '{65536, 65535, 32'h0001_0000, 32'h0, 32'h0004_0000, 0, 1, 0, 0, 0, 0};
    dir_tab[18] = '{65536, 65535, 32'h0003_0000, 32'h0, 32'h0004_0000, 0, 65000, 1, 0, 0, 0};
    dir_tab[19] = '{131071, 3840, 32'h0000_0010, 32'h0, 32'h0000_0020, 65535, 2000, 0, 0, 0,
                    0};
    dir_tab[20] = '{131071, 3840, 32'hffff_fff0, 32'hffff_ffe0, 32'hffff_ffff, 65535, 40000,
                    1, 0, 0, 0};
    dir_tab[21] = '{131071, 3840, 32'h0, 32'h0, 32'h0000_0001, 1, 32768, 0, 0, 0, 0};

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table, reconfigured whenever a row asks for other settings
    foreach (dir_tab[i]) begin
      if (dir_tab[i].prob != cur_prob || dir_tab[i].eta != cur_eta)
        set_config(dir_tab[i].prob, dir_tab[i].eta);
      put_word(dir_tab[i].y, dir_tab[i].yl, dir_tab[i].yu, dir_tab[i].gate,
               dir_tab[i].shape, dir_tab[i].last, dir_tab[i].chk, dir_tab[i].ev,
               dir_tab[i].em);
    end

    // Random words in three idling phases, settings changed every 45 words
    for (int ph = 0; ph < 3; ph++) begin
      in_idle = (ph == 0) ? 34 : (ph == 1) ? 69 : 0;
      out_stall = (ph == 0) ? 69 : (ph == 1) ? 34 : 0;
      for (int blk = 0; blk < 3; blk++) begin
        case ($urandom_range(4))
          0: p = 0;
          1: p = 65536;
          2: p = 131071;
          default: p = 17'($urandom_range(65536));
        endcase
        case ($urandom_range(3))
          0: t = 0;
          1: t = 65535;
          2: t = pmg_pkg::ETA_RESET;
          default: t = 16'($urandom);
        endcase
        set_config(p, t);
        repeat (45) random_word();
      end
    end

    drain();
    repeat (130) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
